/* hdl/bse_pkg.sv */
`default_nettype none

package bse_pkg;

	localparam int MAX_BITS    = 4096;
	localparam int WORD_BITS   = 64;
	localparam int NWORDS      = MAX_BITS / WORD_BITS;
	localparam int ADDR_W      = $clog2(NWORDS);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int CNT_W       = BIT_W + 1;
	localparam int REQ_W       = 3;
	localparam int IDX_W       = 13;
	localparam int SIZE_W      = 13;
	localparam int IN_W        = REQ_W + IDX_W + SIZE_W;
	localparam int OUT_W       = 1 + SIZE_W + IDX_W + 1;
	localparam int TDATA_IN_W  = ((IN_W + 7) / 8) * 8;
	localparam int TDATA_OUT_W = ((OUT_W + 7) / 8) * 8;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR_ALL = 3'd0,
		REQ_FILL      = 3'd1,
		REQ_CLEAR_BIT = 3'd2,
		REQ_SET_BIT   = 3'd3,
		REQ_TEST      = 3'd4,
		REQ_COUNT     = 3'd5,
		REQ_SCAN      = 3'd6,
		REQ_RESIZE    = 3'd7
	} req_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CLEAR_ALL,
		CMD_FILL,
		CMD_BIT_RD,
		CMD_BIT_MOD,
		CMD_COUNT,
		CMD_SCAN,
		CMD_RESIZE,
		CMD_RESIZE_WR,
		CMD_PUSH
	} cmd_t;

	typedef struct packed {
		req_t in_req;
		logic idx_bad;
		logic scan_empty;
		logic resize_part;
		logic ptr_end;
		logic sweep_done;
		logic scan_hit;
		logic out_free;
	} stat_t;

	// bits of word w below the logical size
	function automatic word_t live_mask(input logic [ADDR_W-1:0] w,
			input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] lo;
		logic [SIZE_W-1:0] n;
		word_t m;
		lo = SIZE_W'({w, {BIT_W{1'b0}}});
		n = size - lo;
		if (size <= lo) begin
			m = '0;
		end else if (n >= SIZE_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = ~({WORD_BITS{1'b1}} << n[BIT_W-1:0]);
		end
		return m;
	endfunction

	function automatic logic [CNT_W-1:0] popcount(input word_t x);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			c = c + CNT_W'(x[i]);
		end
		return c;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_one(input word_t x);
		logic [BIT_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (x[i]) begin
				p = BIT_W'(i);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

/* hdl/bse_ram.sv */
`default_nettype none

module bse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/bse_ctrl.sv */
`default_nettype none

module bse_ctrl import bse_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_FILL,
		ST_BIT,
		ST_BIT_MOD,
		ST_COUNT,
		ST_SCAN,
		ST_RESIZE,
		ST_RESIZE_WR,
		ST_DONE
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		unique case (state_q)
			ST_IDLE:      cmd = s_tvalid ? CMD_LOAD : CMD_NONE;
			ST_CLR:       cmd = CMD_CLEAR_ALL;
			ST_FILL:      cmd = stat.ptr_end ? CMD_NONE : CMD_FILL;
			ST_BIT:       cmd = stat.idx_bad ? CMD_NONE : CMD_BIT_RD;
			ST_BIT_MOD:   cmd = CMD_BIT_MOD;
			ST_COUNT:     cmd = CMD_COUNT;
			ST_SCAN:      cmd = stat.scan_empty ? CMD_NONE : CMD_SCAN;
			ST_RESIZE:    cmd = CMD_RESIZE;
			ST_RESIZE_WR: cmd = CMD_RESIZE_WR;
			ST_DONE:      cmd = stat.out_free ? CMD_PUSH : CMD_NONE;
			default:      cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						unique case (stat.in_req)
							REQ_CLEAR_ALL: state_q <= ST_CLR;
							REQ_FILL:      state_q <= ST_FILL;
							REQ_CLEAR_BIT,
							REQ_SET_BIT,
							REQ_TEST:      state_q <= ST_BIT;
							REQ_COUNT:     state_q <= ST_COUNT;
							REQ_SCAN:      state_q <= ST_SCAN;
							REQ_RESIZE:    state_q <= ST_RESIZE;
							default:       state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLR: state_q <= ST_DONE;
				ST_FILL: begin
					if (stat.ptr_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_BIT: state_q <= stat.idx_bad ? ST_DONE : ST_BIT_MOD;
				ST_BIT_MOD: state_q <= ST_DONE;
				ST_COUNT: begin
					if (stat.sweep_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (stat.scan_empty || stat.scan_hit || stat.sweep_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_RESIZE: state_q <= stat.resize_part ? ST_RESIZE_WR : ST_DONE;
				ST_RESIZE_WR: state_q <= ST_DONE;
				ST_DONE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/bse_dpath.sv */
`default_nettype none

module bse_dpath import bse_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [TDATA_OUT_W-1:0] m_tdata,
	input  wire cmd_t                   cmd,
	output stat_t                       stat
);

	localparam int IDX_LSB = REQ_W;
	localparam int NSZ_LSB = REQ_W + IDX_W;

	logic [IDX_W-1:0]  in_idx;
	logic [SIZE_W-1:0] in_nsz;
	req_t              in_req;
	logic              in_neg;
	logic [SIZE_W-1:0] in_start;
	logic              in_bad;
	logic              in_big;
	logic              in_bitop;

	req_t              req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SIZE_W-1:0] start_q;
	logic [SIZE_W-1:0] nsz_q;
	logic [SIZE_W-1:0] size_q;
	logic [NWORDS-1:0] valid_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              idx_bad_q;
	logic              scan_empty_q;

	logic              rd_pend_s1;
	logic              rd_live_s1;
	logic [ADDR_W-1:0] rd_word_s1;

	logic              bitv_q;
	logic [SIZE_W-1:0] cnt_q;
	logic [IDX_W-1:0]  found_q;
	logic              err_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	word_t             ram_wd;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_ra;
	word_t             ram_rd;
	logic              sweep_rd;

	logic              ptr_end;
	logic [ADDR_W-1:0] idx_word;
	logic [BIT_W-1:0]  idx_bit;
	logic [PTR_W-1:0]  rsz_word;
	logic              rsz_part;
	word_t             rd_eff;
	word_t             bit_mask;
	word_t             bit_mod;
	word_t             scan_x;
	logic              scan_hit;

	assign in_req   = req_t'(s_tdata[REQ_W-1:0]);
	assign in_idx   = s_tdata[IDX_LSB +: IDX_W];
	assign in_nsz   = s_tdata[NSZ_LSB +: SIZE_W];
	assign in_neg   = in_idx[IDX_W-1];
	assign in_start = in_neg ? '0 : in_idx + SIZE_W'(1);
	assign in_bad   = in_neg || (in_idx >= size_q);
	assign in_big   = in_nsz > SIZE_W'(MAX_BITS);
	assign in_bitop = (in_req == REQ_CLEAR_BIT) || (in_req == REQ_SET_BIT)
		|| (in_req == REQ_TEST);

	assign ptr_end  = (ptr_q == PTR_W'(NWORDS));
	assign idx_word = idx_q[BIT_W +: ADDR_W];
	assign idx_bit  = idx_q[BIT_W-1:0];
	assign rsz_word = nsz_q[SIZE_W-1:BIT_W];
	assign rsz_part = (nsz_q[BIT_W-1:0] != '0);
	assign rd_eff   = rd_live_s1 ? ram_rd : '0;
	assign bit_mask = word_t'(1) << idx_bit;
	assign bit_mod  = (req_q == REQ_SET_BIT) ? (rd_eff | bit_mask) : (rd_eff & ~bit_mask);

	// first word of a scan skips bits below the start position
	assign scan_x = rd_eff & ((rd_word_s1 == start_q[BIT_W +: ADDR_W])
		? ({WORD_BITS{1'b1}} << start_q[BIT_W-1:0]) : {WORD_BITS{1'b1}});
	assign scan_hit = rd_pend_s1 && (scan_x != '0);

	always_comb begin
		ram_we   = 1'b0;
		ram_wa   = '0;
		ram_wd   = '0;
		ram_re   = 1'b0;
		ram_ra   = '0;
		sweep_rd = 1'b0;
		unique case (cmd)
			CMD_FILL: begin
				ram_we = 1'b1;
				ram_wa = ptr_q[ADDR_W-1:0];
				ram_wd = live_mask(ptr_q[ADDR_W-1:0], size_q);
			end
			CMD_BIT_RD: begin
				ram_re = 1'b1;
				ram_ra = idx_word;
			end
			CMD_BIT_MOD: begin
				ram_we = (req_q != REQ_TEST);
				ram_wa = idx_word;
				ram_wd = bit_mod;
			end
			CMD_COUNT, CMD_SCAN: begin
				ram_re   = !ptr_end;
				sweep_rd = !ptr_end;
				ram_ra   = ptr_q[ADDR_W-1:0];
			end
			CMD_RESIZE: begin
				ram_re = rsz_part;
				ram_ra = rsz_word[ADDR_W-1:0];
			end
			CMD_RESIZE_WR: begin
				ram_we = 1'b1;
				ram_wa = rd_word_s1;
				ram_wd = rd_eff & live_mask(rd_word_s1, size_q);
			end
			default: begin
			end
		endcase
	end

	bse_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (ram_re),
		.rd_addr (ram_ra),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk) begin
		rd_live_s1 <= valid_q[ram_ra];
		rd_word_s1 <= ram_ra;
		unique case (cmd)
			CMD_LOAD: begin
				req_q        <= in_req;
				idx_q        <= in_idx;
				start_q      <= in_start;
				nsz_q        <= in_big ? SIZE_W'(MAX_BITS) : in_nsz;
				idx_bad_q    <= in_bad;
				scan_empty_q <= (in_start >= size_q);
				ptr_q        <= (in_req == REQ_SCAN) ? PTR_W'(in_start >> BIT_W) : '0;
				bitv_q       <= 1'b0;
				cnt_q        <= '0;
				found_q      <= (in_req == REQ_SCAN) ? '1 : '0;
				err_q        <= (in_bitop && in_bad) || ((in_req == REQ_RESIZE) && in_big);
			end
			CMD_FILL: ptr_q <= ptr_q + PTR_W'(1);
			CMD_BIT_MOD: begin
				if (req_q == REQ_TEST) begin
					bitv_q <= rd_eff[idx_bit];
				end
			end
			CMD_COUNT: begin
				if (!ptr_end) begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
				if (rd_pend_s1) begin
					cnt_q <= cnt_q + SIZE_W'(popcount(rd_eff));
				end
			end
			CMD_SCAN: begin
				if (!ptr_end) begin
					ptr_q <= ptr_q + PTR_W'(1);
				end
				if (scan_hit) begin
					found_q <= IDX_W'({rd_word_s1, lowest_one(scan_x)});
				end
			end
			default: begin
			end
		endcase
		if (cmd == CMD_PUSH) begin
			out_data_q <= {err_q, found_q, cnt_q, bitv_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= SIZE_W'(MAX_BITS);
			valid_q     <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= sweep_rd;
			unique case (cmd)
				CMD_CLEAR_ALL: valid_q <= '0;
				CMD_FILL: valid_q[ptr_q[ADDR_W-1:0]] <= 1'b1;
				CMD_BIT_MOD: begin
					if (req_q != REQ_TEST) begin
						valid_q[idx_word] <= 1'b1;
					end
				end
				CMD_RESIZE: begin
					size_q <= nsz_q;
					for (int w = 0; w < NWORDS; w++) begin
						if (SIZE_W'(w * WORD_BITS) >= nsz_q) begin
							valid_q[w] <= 1'b0;
						end
					end
				end
				CMD_RESIZE_WR: valid_q[rd_word_s1] <= 1'b1;
				default: begin
				end
			endcase
			if (cmd == CMD_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_OUT_W - OUT_W){1'b0}}, out_data_q};

	assign stat.in_req      = in_req;
	assign stat.idx_bad     = idx_bad_q;
	assign stat.scan_empty  = scan_empty_q;
	assign stat.resize_part = rsz_part;
	assign stat.ptr_end     = ptr_end;
	assign stat.sweep_done  = ptr_end && !rd_pend_s1;
	assign stat.scan_hit    = scan_hit;
	assign stat.out_free    = !out_valid_q || m_tready;

	a_size_max: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= SIZE_W'(MAX_BITS))
		else $error("logical size above maximum");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_PUSH |-> (!out_valid_q || m_tready))
		else $error("result pushed over a waiting beat");

	a_found_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_PUSH && req_q != REQ_SCAN) |-> (found_q == '0))
		else $error("found index set outside a scan");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_PUSH && err_q) |-> (req_q == REQ_CLEAR_BIT || req_q == REQ_SET_BIT
			|| req_q == REQ_TEST || req_q == REQ_RESIZE))
		else $error("error flag on a request that cannot fail");

endmodule

`default_nettype wire

/* hdl/bitmap_set_engine.sv */
// Bit set of up to 4096 bits held in a 64 x 64-bit RAM with one write and one
// registered read port; one request is worked at a time and each gives one result
// beat. Count, scan and fill walk the RAM one word per cycle (a scan stops at the
// first word with a hit). Clear all drops the word valid flags. A bad bit index or
// an empty scan skips the RAM; a single-bit clear, set or test reads the word, then
// writes it back (a test does not write); a resize also reads and masks the last word when the new size ends inside it.
// A new request is accepted once the previous one is finished, even while its
// result beat still waits on the output register. No clearing pass after reset.
`default_nettype none

module bitmap_set_engine import bse_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// req_type[2:0], bit_index[15:3], new_size[28:16]
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// bit_value[0], set_count[13:1], found_index[26:14], index_error[27]
	output logic      [TDATA_OUT_W-1:0] m_tdata
);

	cmd_t  cmd;
	stat_t stat;

	bse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bse_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

`default_nettype wire
